// ===== src/shp_pkg.sv =====
package shp_pkg;

  localparam int MAX_LEADING_ZEROS = 32;
  localparam logic [4:0] NAL_TYPE_SPS = 5'h7;
  localparam logic [7:0] SAR_ESCAPE_IDC = 8'd255;
  localparam logic [7:0] PROFILE_HIGH = 8'd100;
  localparam logic [31:0] SIZE_MAX_OUT = 32'd65535;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_NOT_SPS = 2'd1;
  localparam logic [1:0] STATUS_UNSUPP  = 2'd2;
  localparam logic [1:0] STATUS_RANGE   = 2'd3;

  typedef enum logic [55:0] {
    ST_HDR        = 56'd1 << 0,  ST_PROFILE  = 56'd1 << 1,  ST_CONSTR   = 56'd1 << 2,
    ST_LEVEL      = 56'd1 << 3,  ST_SPS_ID   = 56'd1 << 4,  ST_CHROMA   = 56'd1 << 5,
    ST_SEP_PLANE  = 56'd1 << 6,  ST_DEPTH_L  = 56'd1 << 7,  ST_DEPTH_C  = 56'd1 << 8,
    ST_BYPASS     = 56'd1 << 9,  ST_SCALE_FLAG = 56'd1 << 10, ST_SCALE_LIST = 56'd1 << 11,
    ST_LOG2_FN    = 56'd1 << 12, ST_POC_TYPE = 56'd1 << 13, ST_POC_LSB  = 56'd1 << 14,
    ST_DELTA_ZERO = 56'd1 << 15, ST_OFF_NONREF = 56'd1 << 16, ST_OFF_TB = 56'd1 << 17,
    ST_NUM_CYCLE  = 56'd1 << 18, ST_OFF_REF  = 56'd1 << 19, ST_MAX_REF  = 56'd1 << 20,
    ST_GAPS       = 56'd1 << 21, ST_WIDTH    = 56'd1 << 22, ST_HEIGHT   = 56'd1 << 23,
    ST_FRAME_ONLY = 56'd1 << 24, ST_MBAFF    = 56'd1 << 25, ST_DIRECT   = 56'd1 << 26,
    ST_CROP_FLAG  = 56'd1 << 27, ST_CROP_L   = 56'd1 << 28, ST_CROP_R   = 56'd1 << 29,
    ST_CROP_T     = 56'd1 << 30, ST_CROP_B   = 56'd1 << 31, ST_VUI_FLAG = 56'd1 << 32,
    ST_AR_FLAG    = 56'd1 << 33, ST_AR_IDC   = 56'd1 << 34, ST_SAR      = 56'd1 << 35,
    ST_OVS_FLAG   = 56'd1 << 36, ST_OVS      = 56'd1 << 37, ST_VST_FLAG = 56'd1 << 38,
    ST_VST        = 56'd1 << 39, ST_COL_FLAG = 56'd1 << 40, ST_COL      = 56'd1 << 41,
    ST_LOC_FLAG   = 56'd1 << 42, ST_LOC_TOP  = 56'd1 << 43, ST_LOC_BOT  = 56'd1 << 44,
    ST_TIM_FLAG   = 56'd1 << 45, ST_TICK     = 56'd1 << 46, ST_SCALE    = 56'd1 << 47,
    ST_FIXED      = 56'd1 << 48, ST_NAL_HRD  = 56'd1 << 49, ST_VCL_HRD  = 56'd1 << 50,
    ST_PIC_STRUCT = 56'd1 << 51, ST_RESTR_FLAG = 56'd1 << 52, ST_MV_OVER = 56'd1 << 53,
    ST_RESTR_UE   = 56'd1 << 54, ST_DONE     = 56'd1 << 55
  } step_e;

  // one bit from the byte feeder
  typedef struct packed {
    logic valid;
    logic bit_val;
    logic beyond;  // zero fill past the final byte
  } bit_t;

  // feeder status
  typedef struct packed {
    logic ready;
    logic flushed;  // final byte shifted out
  } feed_t;

  // parser results
  typedef struct packed {
    logic        done;
    logic        trunc;
    logic [1:0]  err;
    logic [7:0]  prof;
    logic [7:0]  lev;
    logic [31:0] width;
    logic [31:0] height;
    logic [31:0] tick;
    logic [31:0] tbase;
    logic        rate_ok;
    logic        fixed;
  } res_t;

  // width of each fixed read, 0 for Exp-Golomb
  function automatic logic [5:0] step_bits(step_e s);
    logic [5:0] n;
    n = 6'd0;
    case (s)
      ST_HDR, ST_PROFILE, ST_CONSTR, ST_LEVEL, ST_AR_IDC: n = 6'd8;
      ST_SAR, ST_TICK, ST_SCALE: n = 6'd32;
      ST_VST: n = 6'd4;
      ST_COL: n = 6'd24;
      ST_SEP_PLANE, ST_BYPASS, ST_SCALE_FLAG, ST_SCALE_LIST, ST_DELTA_ZERO,
      ST_GAPS, ST_FRAME_ONLY, ST_MBAFF, ST_DIRECT, ST_CROP_FLAG, ST_VUI_FLAG,
      ST_AR_FLAG, ST_OVS_FLAG, ST_OVS, ST_VST_FLAG, ST_COL_FLAG, ST_LOC_FLAG,
      ST_TIM_FLAG, ST_FIXED, ST_NAL_HRD, ST_VCL_HRD, ST_PIC_STRUCT,
      ST_RESTR_FLAG, ST_MV_OVER: n = 6'd1;
      default: n = 6'd0;
    endcase
    return n;
  endfunction

  function automatic logic high_profile(logic [7:0] p);
    return p == PROFILE_HIGH || p == 8'd110 || p == 8'd122 || p == 8'd244 ||
           p == 8'd44 || p == 8'd83 || p == 8'd86 || p == 8'd118 ||
           p == 8'd128 || p == 8'd138 || p == 8'd139 || p == 8'd134 ||
           p == 8'd135;
  endfunction

endpackage

// ===== src/shp_byte_feed.sv =====
module shp_byte_feed import shp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       clear_i,
  input  logic       load_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  output bit_t       bit_o,
  output feed_t      stat_o
);

  logic [7:0] sreg_q, sreg_d;
  logic [3:0] cnt_q, cnt_d;
  logic [1:0] zrun_q, zrun_d;
  logic       last_q, last_d;

  // emulation-prevention filter and MSB-first shift out
  always_comb begin
    sreg_d = sreg_q;
    cnt_d  = cnt_q;
    zrun_d = zrun_q;
    last_d = last_q;
    if (clear_i) begin
      cnt_d  = 4'd0;
      zrun_d = 2'd0;
      last_d = 1'b0;
    end else if (load_i) begin
      last_d = last_i;
      if (zrun_q == 2'd2 && byte_i == 8'h03) begin
        zrun_d = 2'd0;
      end else begin
        sreg_d = byte_i;
        cnt_d  = 4'd8;
        zrun_d = (byte_i == 8'h00) ? ((zrun_q < 2'd2) ? zrun_q + 2'd1 : 2'd2) : 2'd0;
      end
    end else if (cnt_q != 4'd0) begin
      sreg_d = {sreg_q[6:0], 1'b0};
      cnt_d  = cnt_q - 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= 4'd0;
      zrun_q <= 2'd0;
      last_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      zrun_q <= zrun_d;
      last_q <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sreg_q <= sreg_d;
  end

  assign bit_o.valid   = (cnt_q != 4'd0) || last_q;
  assign bit_o.bit_val = (cnt_q != 4'd0) && sreg_q[7];
  assign bit_o.beyond  = (cnt_q == 4'd0);
  assign stat_o.ready   = (cnt_q == 4'd0) && !last_q;
  assign stat_o.flushed = (cnt_q == 4'd0) && last_q;

endmodule

// ===== src/shp_syntax.sv =====
module shp_syntax import shp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic clear_i,
  input  bit_t bit_i,
  output res_t res_o
);

  step_e       step_q, step_d, nxt;
  logic [31:0] acc_q, acc_d, acc_sh;
  logic [5:0]  bleft_q, bleft_d;
  logic [5:0]  gz_q, gz_d;
  logic        suffix_q, suffix_d;
  logic [31:0] loop_q, loop_d, loop_m1;
  logic [1:0]  cf_q, cf_d;
  logic        fo_q, fo_d;
  logic [31:0] w_q, w_d, h_q, h_d, tick_q, tick_d, tb_q, tb_d;
  logic        rok_q, rok_d, fix_q, fix_d;
  logic [7:0]  prof_q, prof_d, lev_q, lev_d;
  logic [1:0]  err_q, err_d, err_val;
  logic        trunc_q, trunc_d;

  logic        fin, go, flag, set_err;
  logic [31:0] fv;
  logic [32:0] ue_sum, ue_mask;
  logic [32:0] wv, hv;
  logic [36:0] wwide;
  logic [37:0] hwide;
  logic [33:0] amt, cmp_acc;
  logic [1:0]  csh;

  assign acc_sh  = {acc_q[30:0], bit_i.bit_val};
  assign loop_m1 = loop_q - 32'd1;
  assign ue_mask = (33'd1 << gz_q) - 33'd1;

  always_comb begin
    step_d = step_q; acc_d = acc_q; bleft_d = bleft_q; gz_d = gz_q;
    suffix_d = suffix_q; loop_d = loop_q; cf_d = cf_q; fo_d = fo_q;
    w_d = w_q; h_d = h_q; tick_d = tick_q; tb_d = tb_q; rok_d = rok_q;
    fix_d = fix_q; prof_d = prof_q; lev_d = lev_q; trunc_d = trunc_q;
    err_d = err_q; err_val = STATUS_OK;
    fin = 1'b0; go = 1'b0; flag = 1'b0; set_err = 1'b0;
    fv = 32'd0; nxt = step_q; ue_sum = 33'd0;
    wv = 33'd0; hv = 33'd0; wwide = 37'd0; hwide = 38'd0;
    amt = 34'd0; cmp_acc = 34'd0; csh = 2'd0;

    // consume one bit
    if (bit_i.valid && step_q != ST_DONE) begin
      if (bit_i.beyond) trunc_d = 1'b1;
      if (step_bits(step_q) != 6'd0) begin
        acc_d   = acc_sh;
        bleft_d = bleft_q - 6'd1;
        if (bleft_q == 6'd1) begin
          fin = 1'b1;
          fv  = acc_sh;
        end
      end else if (!suffix_q) begin
        // Exp-Golomb prefix
        if (bit_i.beyond || gz_q >= 6'(MAX_LEADING_ZEROS) || bit_i.bit_val) begin
          if (gz_q == 6'd0) begin
            fin = 1'b1;
          end else begin
            suffix_d = 1'b1;
            bleft_d  = gz_q;
            acc_d    = 32'd0;
          end
        end else begin
          gz_d = gz_q + 6'd1;
        end
      end else begin
        acc_d   = acc_sh;
        bleft_d = bleft_q - 6'd1;
        if (bleft_q == 6'd1) begin
          fin    = 1'b1;
          ue_sum = ue_mask + {1'b0, acc_sh};
          if (ue_sum[32]) begin
            flag = 1'b1;
            fv   = 32'hFFFF_FFFF;
          end else begin
            fv = ue_sum[31:0];
          end
        end
      end
    end

    // syntax walk at the end of each element
    if (fin) begin
      go = 1'b1;
      case (step_q)
        ST_HDR: begin
          if (fv[4:0] != NAL_TYPE_SPS) begin
            set_err = 1'b1; err_val = STATUS_NOT_SPS; nxt = ST_DONE;
          end else nxt = ST_PROFILE;
        end
        ST_PROFILE: begin prof_d = fv[7:0]; nxt = ST_CONSTR; end
        ST_CONSTR:  nxt = ST_LEVEL;
        ST_LEVEL:   begin lev_d = fv[7:0]; nxt = ST_SPS_ID; end
        ST_SPS_ID:  nxt = high_profile(prof_q) ? ST_CHROMA : ST_LOG2_FN;
        ST_CHROMA: begin
          if (fv > 32'd3) begin
            flag = 1'b1; cf_d = 2'd3; nxt = ST_SEP_PLANE;
          end else begin
            cf_d = fv[1:0];
            nxt  = (fv[1:0] == 2'd3) ? ST_SEP_PLANE : ST_DEPTH_L;
          end
        end
        ST_SEP_PLANE: nxt = ST_DEPTH_L;
        ST_DEPTH_L:   nxt = ST_DEPTH_C;
        ST_DEPTH_C:   nxt = ST_BYPASS;
        ST_BYPASS:    nxt = ST_SCALE_FLAG;
        ST_SCALE_FLAG: begin
          if (fv[0]) begin
            loop_d = (cf_q == 2'd3) ? 32'd12 : 32'd8;
            nxt    = ST_SCALE_LIST;
          end else nxt = ST_LOG2_FN;
        end
        ST_SCALE_LIST: begin
          if (fv[0]) begin
            set_err = 1'b1; err_val = STATUS_UNSUPP; nxt = ST_DONE;
          end else begin
            loop_d = loop_m1;
            nxt    = (loop_m1 == 32'd0) ? ST_LOG2_FN : ST_SCALE_LIST;
          end
        end
        ST_LOG2_FN: nxt = ST_POC_TYPE;
        ST_POC_TYPE: begin
          if (fv == 32'd0) nxt = ST_POC_LSB;
          else if (fv == 32'd1) nxt = ST_DELTA_ZERO;
          else begin
            if (fv > 32'd2) flag = 1'b1;
            nxt = ST_MAX_REF;
          end
        end
        ST_POC_LSB:    nxt = ST_MAX_REF;
        ST_DELTA_ZERO: nxt = ST_OFF_NONREF;
        ST_OFF_NONREF: nxt = ST_OFF_TB;
        ST_OFF_TB:     nxt = ST_NUM_CYCLE;
        ST_NUM_CYCLE: begin
          loop_d = fv;
          nxt    = (fv == 32'd0 || bit_i.beyond) ? ST_MAX_REF : ST_OFF_REF;
        end
        ST_OFF_REF: begin
          loop_d = loop_m1;
          nxt    = (loop_m1 == 32'd0 || bit_i.beyond) ? ST_MAX_REF : ST_OFF_REF;
        end
        ST_MAX_REF: nxt = ST_GAPS;
        ST_GAPS:    nxt = ST_WIDTH;
        ST_WIDTH: begin
          wv    = {1'b0, fv} + 33'd1;
          wwide = {wv, 4'b0};
          if (wwide[36:32] != 5'd0) begin flag = 1'b1; w_d = 32'hFFFF_FFFF; end
          else w_d = wwide[31:0];
          nxt = ST_HEIGHT;
        end
        ST_HEIGHT: begin h_d = fv; nxt = ST_FRAME_ONLY; end
        ST_FRAME_ONLY: begin
          fo_d  = fv[0];
          hv    = {1'b0, h_q} + 33'd1;
          hwide = {1'b0, hv, 4'b0};
          if (!fv[0]) hwide = {hwide[36:0], 1'b0};
          if (hwide[37:32] != 6'd0) begin flag = 1'b1; h_d = 32'hFFFF_FFFF; end
          else h_d = hwide[31:0];
          nxt = fv[0] ? ST_DIRECT : ST_MBAFF;
        end
        ST_MBAFF:     nxt = ST_DIRECT;
        ST_DIRECT:    nxt = ST_CROP_FLAG;
        ST_CROP_FLAG: nxt = fv[0] ? ST_CROP_L : ST_VUI_FLAG;
        ST_CROP_L, ST_CROP_R: begin
          csh     = (cf_q == 2'd1 || cf_q == 2'd2) ? 2'd1 : 2'd0;
          amt     = {2'b0, fv} << csh;
          cmp_acc = {2'b0, w_q};
          if (amt > cmp_acc) begin w_d = 32'd0; flag = 1'b1; end
          else w_d = w_q - amt[31:0];
          nxt = (step_q == ST_CROP_L) ? ST_CROP_R : ST_CROP_T;
        end
        ST_CROP_T, ST_CROP_B: begin
          csh     = (fo_q ? 2'd0 : 2'd1) + ((cf_q == 2'd1) ? 2'd1 : 2'd0);
          amt     = {2'b0, fv} << csh;
          cmp_acc = {2'b0, h_q};
          if (amt > cmp_acc) begin h_d = 32'd0; flag = 1'b1; end
          else h_d = h_q - amt[31:0];
          nxt = (step_q == ST_CROP_T) ? ST_CROP_B : ST_VUI_FLAG;
        end
        ST_VUI_FLAG: nxt = fv[0] ? ST_AR_FLAG : ST_DONE;
        ST_AR_FLAG:  nxt = fv[0] ? ST_AR_IDC : ST_OVS_FLAG;
        ST_AR_IDC:   nxt = (fv[7:0] == SAR_ESCAPE_IDC) ? ST_SAR : ST_OVS_FLAG;
        ST_SAR:      nxt = ST_OVS_FLAG;
        ST_OVS_FLAG: nxt = fv[0] ? ST_OVS : ST_VST_FLAG;
        ST_OVS:      nxt = ST_VST_FLAG;
        ST_VST_FLAG: nxt = fv[0] ? ST_VST : ST_LOC_FLAG;
        ST_VST:      nxt = ST_COL_FLAG;
        ST_COL_FLAG: nxt = fv[0] ? ST_COL : ST_LOC_FLAG;
        ST_COL:      nxt = ST_LOC_FLAG;
        ST_LOC_FLAG: nxt = fv[0] ? ST_LOC_TOP : ST_TIM_FLAG;
        ST_LOC_TOP:  nxt = ST_LOC_BOT;
        ST_LOC_BOT:  nxt = ST_TIM_FLAG;
        ST_TIM_FLAG: nxt = fv[0] ? ST_TICK : ST_NAL_HRD;
        ST_TICK:     begin tick_d = fv; nxt = ST_SCALE; end
        ST_SCALE:    begin tb_d = fv; nxt = ST_FIXED; end
        ST_FIXED:    begin rok_d = 1'b1; fix_d = fv[0]; nxt = ST_NAL_HRD; end
        ST_NAL_HRD, ST_VCL_HRD: begin
          if (fv[0]) begin
            set_err = 1'b1; err_val = STATUS_UNSUPP; nxt = ST_DONE;
          end else nxt = (step_q == ST_NAL_HRD) ? ST_VCL_HRD : ST_PIC_STRUCT;
        end
        ST_PIC_STRUCT: nxt = ST_RESTR_FLAG;
        ST_RESTR_FLAG: nxt = fv[0] ? ST_MV_OVER : ST_DONE;
        ST_MV_OVER:    begin loop_d = 32'd6; nxt = ST_RESTR_UE; end
        ST_RESTR_UE: begin
          loop_d = loop_m1;
          nxt    = (loop_m1 == 32'd0) ? ST_DONE : ST_RESTR_UE;
        end
        default: nxt = ST_DONE;
      endcase
    end

    // start the next element
    if (go) begin
      step_d   = nxt;
      acc_d    = 32'd0;
      gz_d     = 6'd0;
      suffix_d = 1'b0;
      bleft_d  = step_bits(nxt);
    end

    if (set_err) err_d = err_val;
    else if (flag && err_q == STATUS_OK) err_d = STATUS_RANGE;

    if (clear_i) begin
      step_d = ST_HDR; acc_d = 32'd0; gz_d = 6'd0; suffix_d = 1'b0;
      bleft_d = step_bits(ST_HDR); loop_d = 32'd0; cf_d = 2'd1; fo_d = 1'b0;
      w_d = 32'd0; h_d = 32'd0; tick_d = 32'd0; tb_d = 32'd0; rok_d = 1'b0;
      fix_d = 1'b0; prof_d = 8'd0; lev_d = 8'd0; err_d = STATUS_OK;
      trunc_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ST_HDR; acc_q <= 32'd0; bleft_q <= 6'd8; gz_q <= 6'd0;
      suffix_q <= 1'b0; loop_q <= 32'd0; cf_q <= 2'd1; fo_q <= 1'b0;
      w_q <= 32'd0; h_q <= 32'd0; tick_q <= 32'd0; tb_q <= 32'd0;
      rok_q <= 1'b0; fix_q <= 1'b0; prof_q <= 8'd0; lev_q <= 8'd0;
      err_q <= STATUS_OK; trunc_q <= 1'b0;
    end else begin
      step_q <= step_d; acc_q <= acc_d; bleft_q <= bleft_d; gz_q <= gz_d;
      suffix_q <= suffix_d; loop_q <= loop_d; cf_q <= cf_d; fo_q <= fo_d;
      w_q <= w_d; h_q <= h_d; tick_q <= tick_d; tb_q <= tb_d;
      rok_q <= rok_d; fix_q <= fix_d; prof_q <= prof_d; lev_q <= lev_d;
      err_q <= err_d; trunc_q <= trunc_d;
    end
  end

  assign res_o.done    = (step_q == ST_DONE);
  assign res_o.trunc   = trunc_q;
  assign res_o.err     = err_q;
  assign res_o.prof    = prof_q;
  assign res_o.lev     = lev_q;
  assign res_o.width   = w_q;
  assign res_o.height  = h_q;
  assign res_o.tick    = tick_q;
  assign res_o.tbase   = tb_q;
  assign res_o.rate_ok = rok_q;
  assign res_o.fixed   = fix_q;

endmodule

// ===== src/shp_div.sv =====
module shp_div import shp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [31:0] quot_o
);

  logic [31:0] rem_q, rem_d, quo_q, quo_d, dvs_q, dvs_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        done_q, done_d;
  logic [32:0] trial;
  logic        ge;

  // restoring division, one quotient bit per cycle
  assign trial = {rem_q, quo_q[31]};
  assign ge    = trial >= {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d = 32'd0;
      quo_d = dividend_i;
      dvs_d = divisor_i;
      cnt_d = 6'd32;
    end else if (cnt_q != 6'd0) begin
      rem_d  = ge ? 32'(trial - {1'b0, dvs_q}) : trial[31:0];
      quo_d  = {quo_q[30:0], ge};
      cnt_d  = cnt_q - 6'd1;
      done_d = (cnt_q == 6'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= 6'd0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// ===== src/h264_sps_header_parser.sv =====
// Channel   Dir  Beat fields (tdata, lowest bit first)
// s_axis    in   sps_byte[7:0]; tlast = last_byte
// m_axis    out  status[1:0] truncated[2] profile[10:3] level[18:11]
//                frame_width[34:19] frame_height[50:35] frame_rate[82:51]
//
// Each kept byte is loaded and then its bits are shifted into the parser,
// one syntax bit per cycle; a dropped 0x03 byte is taken and discarded.
// After the last byte the parser runs on zero fill until the syntax ends,
// then the frame rate divider builds its quotient bit by bit, and once it
// is done the emit state loads the result into the output register.
// Reset clears all control state. The input stalls from the last byte of a
// unit until its result is loaded, which waits while the output is full.
module h264_sps_header_parser import shp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // sps_byte
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata    // status, truncated, profile, level,
                                      // frame_width, frame_height, frame_rate
);

  typedef enum logic [2:0] {
    S_RUN  = 3'b001,
    S_DIV  = 3'b010,
    S_EMIT = 3'b100
  } state_e;

  state_e      state_q, state_d;
  bit_t        fbit;
  feed_t       fstat;
  res_t        res;
  logic        load, clear, div_start, div_done;
  logic [31:0] quot, rate;
  logic [15:0] w16, h16;
  logic [1:0]  status;
  logic        over;
  logic        ovalid_q, ovalid_d;
  logic [87:0] odata_q, odata_d;

  assign s_axis_tready = fstat.ready;
  assign load = s_axis_tvalid && fstat.ready;

  shp_byte_feed u_feed (
    .clk_i, .rst_ni, .clear_i(clear), .load_i(load),
    .byte_i(s_axis_tdata), .last_i(s_axis_tlast), .bit_o(fbit), .stat_o(fstat)
  );

  shp_syntax u_syntax (
    .clk_i, .rst_ni, .clear_i(clear), .bit_i(fbit), .res_o(res)
  );

  shp_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(res.tbase),
    .divisor_i(res.tick), .done_o(div_done), .quot_o(quot)
  );

  // result formatting
  always_comb begin
    over = (res.width > SIZE_MAX_OUT) || (res.height > SIZE_MAX_OUT);
    w16  = (res.width > SIZE_MAX_OUT) ? 16'hFFFF : res.width[15:0];
    h16  = (res.height > SIZE_MAX_OUT) ? 16'hFFFF : res.height[15:0];
    status = (res.err == STATUS_OK && over) ? STATUS_RANGE : res.err;
    rate = 32'd0;
    if (res.rate_ok && res.tick != 32'd0) rate = res.fixed ? {1'b0, quot[31:1]} : quot;
    odata_d = {5'd0, rate, h16, w16, res.lev, res.prof, res.trunc, status};
  end

  // sequencing
  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    clear     = 1'b0;
    ovalid_d  = ovalid_q && !m_axis_tready;
    case (state_q)
      S_RUN: begin
        if (fstat.flushed && res.done) begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end
      end
      S_DIV: if (div_done) state_d = S_EMIT;
      S_EMIT: begin
        if (!ovalid_q || m_axis_tready) begin
          ovalid_d = 1'b1;
          clear    = 1'b1;
          state_d  = S_RUN;
        end
      end
      default: state_d = S_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_RUN;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_EMIT && (!ovalid_q || m_axis_tready)) odata_q <= odata_d;
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;

endmodule

// ===== src/shp_checker.sv =====
module shp_checker import shp_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [87:0] m_axis_tdata
);

  // a stalled result beat holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed under stall");

  // the final byte is not followed straight away by a ready input
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("byte accepted right after final byte");

  // a non-SPS unit reports empty fields
  a_not_sps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1:0] == STATUS_NOT_SPS |->
      m_axis_tdata[87:3] == 85'd0)
    else $error("non-SPS result carries fields");

  // a non-SPS unit stops at the header, never past the end
  a_not_sps_trunc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1:0] == STATUS_NOT_SPS |-> !m_axis_tdata[2])
    else $error("non-SPS result marked truncated");

endmodule

bind h264_sps_header_parser shp_checker u_shp_checker (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tlast,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);
